FILE: rtl/sbri_pkg.sv
// sbri_pkg: types, constants and codes for the sorted block rank index
// used by the channel interfaces, the table cell and the top level
`default_nettype none

package sbri_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int BLOCK_W         = 21;
	localparam int OFF_W           = 10;
	localparam int ID_W            = 32;
	localparam int INDEX_W         = 16;
	localparam int INDEX_MAX       = 32767;

	typedef enum logic {
		OP_REGISTER = 1'b0,
		OP_LOOKUP   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_UPD
	} fsm_t;

	typedef struct packed {
		logic               cmp_en;
		logic               upd_en;
		logic [BLOCK_W-1:0] key;
	} cell_ctl_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

`default_nettype wire

FILE: rtl/sbri_req_if.sv
// sbri_req_if: input channel, valid/ready handshake with operation and id
// depends on sbri_pkg for field widths
`default_nettype none

interface sbri_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic signed [sbri_pkg::ID_W-1:0] id_value;

	modport source (output valid, output operation, output id_value, input ready);
	modport sink   (input valid, input operation, input id_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbri_rsp_if.sv
// sbri_rsp_if: result channel, valid/ready handshake with local index and status
// depends on sbri_pkg for field widths
`default_nettype none

interface sbri_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [sbri_pkg::INDEX_W-1:0] local_index;
	logic [1:0]                          status;

	modport source (output valid, output local_index, output status, input ready);
	modport sink   (input valid, input local_index, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbri_cell.sv
// sbri_cell: one entry of the sorted table, compares against the key and
// shifts up from its lower neighbor on insert; depends on sbri_pkg
`default_nettype none

module sbri_cell (
	input  wire                                clk,
	input  wire sbri_pkg::cell_ctl_t           ctl,
	input  wire                                entry_valid,
	input  wire                                prev_lt,
	input  wire [sbri_pkg::BLOCK_W-1:0]        prev_entry,
	output sbri_pkg::cell_flags_t              flags,
	output logic [sbri_pkg::BLOCK_W-1:0]       entry
);

	logic [sbri_pkg::BLOCK_W-1:0] entry_q;
	logic                         lt_q;
	logic                         eq_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			lt_q <= entry_valid && (entry_q < ctl.key);
			eq_q <= entry_valid && (entry_q == ctl.key);
		end
		if (ctl.upd_en && !lt_q) begin
			entry_q <= prev_lt ? ctl.key : prev_entry;
		end
	end

	assign flags.lt = lt_q;
	assign flags.eq = eq_q;
	assign entry    = entry_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_block_rank_index.sv
// Sorted block rank index. Keeps an ascending table of distinct block numbers in a
// chain of cells. An item is accepted, compared against every cell in the next cycle,
// and once the output register is free the chain shifts to insert the block and the
// result is registered. A new item is taken only while idle or as the previous one
// leaves the compare-then-shift step of the cell chain; the result waits in an output
// register, and the update cycle holds while that register is still occupied. Register
// items give local_index 0. Table contents need no clearing after reset; the fill count,
// state and output valid are reset. Depends on sbri_pkg, sbri_req_if, sbri_rsp_if and sbri_cell
`default_nettype none

module sorted_block_rank_index #(
	parameter int TABLE_DEPTH = sbri_pkg::TABLE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	sbri_req_if.sink   req,
	sbri_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int RAW_W = sbri_pkg::OFF_W + CNT_W + 1;
	localparam int VAL_W = (RAW_W > sbri_pkg::INDEX_W) ? RAW_W : sbri_pkg::INDEX_W;

	sbri_pkg::fsm_t state_q, state_d;

	logic                              lookup_q;
	logic                              bad_q;
	logic [sbri_pkg::BLOCK_W-1:0]      key_q;
	logic [sbri_pkg::OFF_W-1:0]        off_q;
	logic [CNT_W-1:0]                  count_q;

	logic                              out_valid_q;
	logic [sbri_pkg::INDEX_W-1:0]      index_q;
	logic [1:0]                        status_q;

	logic                              upd_go;
	logic                              accept;
	logic                              cmp_en;

	logic [sbri_pkg::ID_W-1:0]         raw;
	logic [sbri_pkg::ID_W-1:0]         id0;
	logic                              nonpos;
	logic                              is_lookup;

	logic [TABLE_DEPTH-1:0]            lt_vec;
	logic [TABLE_DEPTH-1:0]            eq_vec;
	logic [TABLE_DEPTH:0]              boundary;
	logic [CNT_W-1:0]                  rank;
	logic                              present;
	logic                              full;
	logic                              do_insert;
	logic [VAL_W-1:0]                  value;
	logic [sbri_pkg::INDEX_W-1:0]      index_d;
	sbri_pkg::status_t                 status_d;

	sbri_pkg::cell_ctl_t               ctl;
	sbri_pkg::cell_flags_t             flags [TABLE_DEPTH];
	logic [sbri_pkg::BLOCK_W-1:0]      entries [TABLE_DEPTH];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbri_pkg::FSM_IDLE: begin
				if (req.valid) state_d = sbri_pkg::FSM_CMP;
			end
			sbri_pkg::FSM_CMP: begin
				state_d = sbri_pkg::FSM_UPD;
			end
			sbri_pkg::FSM_UPD: begin
				if (upd_go) state_d = req.valid ? sbri_pkg::FSM_CMP : sbri_pkg::FSM_IDLE;
			end
			default: begin
				state_d = sbri_pkg::FSM_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		upd_go    = 1'b0;
		cmp_en    = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			sbri_pkg::FSM_IDLE: begin
				req.ready = 1'b1;
			end
			sbri_pkg::FSM_CMP: begin
				cmp_en = 1'b1;
			end
			sbri_pkg::FSM_UPD: begin
				upd_go    = !out_valid_q || rsp.ready;
				req.ready = upd_go;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbri_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// decode of the incoming item
	assign raw       = req.id_value;
	assign id0       = raw - sbri_pkg::ID_W'(1);
	assign nonpos    = raw[sbri_pkg::ID_W-1] || (raw == '0);
	assign is_lookup = (req.operation == sbri_pkg::OP_LOOKUP);

	always_ff @(posedge clk) begin
		if (accept) begin
			lookup_q <= is_lookup;
			off_q    <= id0[sbri_pkg::OFF_W-1:0];
			if (is_lookup) begin
				bad_q <= nonpos;
				key_q <= id0[sbri_pkg::OFF_W +: sbri_pkg::BLOCK_W];
			end else begin
				bad_q <= nonpos || (|raw[sbri_pkg::ID_W-2:sbri_pkg::BLOCK_W]);
				key_q <= raw[sbri_pkg::BLOCK_W-1:0];
			end
		end
	end

	// cell chain
	assign ctl.cmp_en = cmp_en;
	assign ctl.upd_en = upd_go && do_insert;
	assign ctl.key    = key_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic                         prev_lt;
		logic [sbri_pkg::BLOCK_W-1:0] prev_entry;
		if (i == 0) begin : g_head
			assign prev_lt    = 1'b1;
			assign prev_entry = key_q;
		end else begin : g_link
			assign prev_lt    = flags[i-1].lt;
			assign prev_entry = entries[i-1];
		end
		sbri_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.entry_valid (count_q > CNT_W'(i)),
			.prev_lt     (prev_lt),
			.prev_entry  (prev_entry),
			.flags       (flags[i]),
			.entry       (entries[i])
		);
		assign lt_vec[i] = flags[i].lt;
		assign eq_vec[i] = flags[i].eq;
	end

	// rank from the edge of the less-than run
	always_comb begin
		boundary[0]           = !lt_vec[0];
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			boundary[i] = lt_vec[i-1] && !lt_vec[i];
		end
		boundary[TABLE_DEPTH] = lt_vec[TABLE_DEPTH-1];
		rank = '0;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			if (boundary[i]) rank = rank | CNT_W'(i);
		end
	end

	assign present   = |eq_vec;
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign do_insert = !bad_q && !present && !full;
	assign value     = VAL_W'({rank, off_q}) + VAL_W'(1);

	always_comb begin
		index_d  = '0;
		status_d = sbri_pkg::STAT_OK;
		if (bad_q) begin
			status_d = sbri_pkg::STAT_IGNORED;
			if (lookup_q) index_d = '1;
		end else if (!present && full) begin
			status_d = sbri_pkg::STAT_FULL;
			if (lookup_q) index_d = '1;
		end else if (lookup_q) begin
			if (value > VAL_W'(sbri_pkg::INDEX_MAX)) begin
				status_d = sbri_pkg::STAT_FULL;
				index_d  = '1;
			end else begin
				index_d = value[sbri_pkg::INDEX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go && do_insert) count_q <= count_q + CNT_W'(1);
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			index_q  <= index_d;
			status_q <= status_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.local_index = index_q;
	assign rsp.status      = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count above table depth");

	a_lt_thermometer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbri_pkg::FSM_UPD) |-> (((lt_vec >> 1) & ~lt_vec) == '0))
		else $error("less-than flags not contiguous");

	a_eq_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbri_pkg::FSM_UPD) |-> $onehot0(eq_vec))
		else $error("duplicate block in table");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && do_insert) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not advance fill count");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbri_pkg::FSM_UPD && !upd_go) |=> (state_q == sbri_pkg::FSM_UPD))
		else $error("update left while result slot busy");

endmodule

`default_nettype wire
